@@ hw/rtl/etps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etps_pkg
// Shared types, constants and the sine table builder for the enveloped
// tone / PCM audio source.
// ----------------------------------------------------------------------------
package etps_pkg;

    // Default sizes of the storage and the phase accumulator.
    localparam int PCM_DEPTH_DEF      = 4096;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF     = 32;

    // Fixed field widths.
    localparam int REQ_W        = 2;
    localparam int PCM_ADDR_W   = 12;
    localparam int PCM_DATA_W   = 16;
    localparam int PCM_LEN_W    = 13;
    localparam int ENV_W        = 16;
    localparam int STEP_W       = 32;
    localparam int SAMPLE_W     = 18;
    localparam int SINE_MAG_W   = 15;
    localparam int SRC_MAG_W    = 17;

    // Envelope scale: Q15, one is 2^15, computed by a restoring divider.
    localparam int                ENV_FRAC_BITS = 15;
    localparam logic [ENV_W-1:0]  SCALE_ONE     = 16'h8000;

    // Configuration register map, one register per word.
    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_PHASE_STEP = 3'd1,
        REG_ENV_COUNT  = 3'd2,
        REG_PCM_LENGTH = 3'd3,
        REG_PCM_HOLD   = 3'd4
    } cfg_reg_t;

    // Request kinds carried in tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK      = 2'd0,
        REQ_ENABLE    = 2'd1,
        REQ_PCM_WRITE = 2'd2
    } req_type_t;

    // Reset values of the configuration registers.
    localparam logic [ENV_W-1:0]     ENV_COUNT_RST  = 16'd480;
    localparam logic [PCM_LEN_W-1:0] PCM_LENGTH_RST = 13'd1;
    localparam logic [ENV_W-1:0]     PCM_HOLD_RST   = 16'd1;

    // First-quadrant sine magnitude in Q15 for index i of a quarter wave of
    // 2^(addr_bits-2) steps. Odd Taylor series to degree 11 in unsigned Q30
    // Horner form, products truncated, then rounded and saturated.
    // Evaluated at elaboration only.
    function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned i,
                                                           input int unsigned addr_bits);
        logic [63:0] q;
        logic [63:0] q2;
        logic [63:0] t;
        logic [63:0] s;
        q  = 64'(i) << (30 - (addr_bits - 2));
        q2 = (q * q) >> 30;
        t  = 64'd3864;
        t  = 64'd172272     - ((q2 * t) >> 30);
        t  = 64'd5026995    - ((q2 * t) >> 30);
        t  = 64'd85569304   - ((q2 * t) >> 30);
        t  = 64'd693598669  - ((q2 * t) >> 30);
        t  = 64'd1686629713 - ((q2 * t) >> 30);
        s  = (q * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        return (s > 64'd32767) ? 15'h7FFF : s[SINE_MAG_W-1:0];
    endfunction

endpackage

@@ hw/rtl/enveloped_tone_pcm_synth.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enveloped_tone_pcm_synth
// Audio source stepped by tick beats: sine tone or PCM table playback,
// scaled by a linear four-state envelope, one signed Q2.15 sample per tick.
// ----------------------------------------------------------------------------
// Each input beat is a sample tick, an enable event or a PCM table write.
// Enable events, table writes and unknown requests give no output beat. A tick
// while the envelope is silent gives a zero sample; a tick while the envelope
// is fully on passes the multiply and output steps, as does a ramp tick whose
// scale is exactly one (the first tick of a ramp down, or a rising ramp whose
// length was lowered under way). Any other ramp tick first runs the 15-step
// restoring divider for the envelope scale floor(num * 2^15 / count), num
// being the ramp position when rising and count minus it when falling. The
// next beat is taken as soon as the previous tick has reached the output
// register, even while that sample still waits on m_axis_tready. The PCM
// table lives in a synchronous single-port memory and the sine quarter wave
// in a registered ROM; never-written table entries read back undefined data.
// Configuration registers (APB, word addresses): 0 mode, 1 phase_step,
// 2 env_count, 3 pcm_length, 4 pcm_hold; write them only while idle.
module enveloped_tone_pcm_synth #(
    parameter int PCM_DEPTH      = etps_pkg::PCM_DEPTH_DEF,
    parameter int SINE_ADDR_BITS = etps_pkg::SINE_ADDR_BITS_DEF,
    parameter int PHASE_BITS     = etps_pkg::PHASE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: enable [0], pcm_addr [12:1], pcm_data [28:13], zero [31:29]
    input  logic [31:0] s_axis_tdata,
    // tuser: req_type [1:0]
    input  logic [1:0]  s_axis_tuser,

    // Sample stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: sample [17:0], zero [23:18]
    output logic [23:0] m_axis_tdata
);

    localparam int PPOS_W     = $clog2(PCM_DEPTH);
    localparam int LEN_W      = ($clog2(PCM_DEPTH + 1) > etps_pkg::PCM_LEN_W) ?
                                $clog2(PCM_DEPTH + 1) : etps_pkg::PCM_LEN_W;
    localparam int QSIZE      = 2 ** (SINE_ADDR_BITS - 2);
    localparam int SINE_IDX_W = SINE_ADDR_BITS - 1;
    localparam int DIV_CNT_W  = $clog2(etps_pkg::ENV_FRAC_BITS + 1);
    localparam int ENV_W      = etps_pkg::ENV_W;
    localparam int PROD_W     = etps_pkg::SRC_MAG_W + ENV_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        ENV_SILENT,
        ENV_UP,
        ENV_ACTIVE,
        ENV_DOWN
    } env_phase_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                          state_reg, state_next;
    env_phase_t                      env_phase_reg, env_phase_next;
    logic [ENV_W-1:0]                env_pos_reg, env_pos_next;
    logic [PHASE_BITS-1:0]           phase_acc_reg, phase_acc_next;
    logic [PPOS_W-1:0]               play_pos_reg, play_pos_next;
    logic [ENV_W-1:0]                hold_count_reg, hold_count_next;

    logic                            mode_reg;
    logic [etps_pkg::STEP_W-1:0]     phase_step_reg;
    logic [ENV_W-1:0]                env_count_reg;
    logic [etps_pkg::PCM_LEN_W-1:0]  pcm_length_reg;
    logic [ENV_W-1:0]                pcm_hold_reg;

    logic [DIV_CNT_W-1:0]            div_cnt_reg, div_cnt_next;
    logic [ENV_W-1:0]                rem_reg, rem_next;
    logic [ENV_W-1:0]                scale_reg, scale_next;
    logic [PROD_W-1:0]               prod_reg, prod_next;
    logic                            neg_reg, neg_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [etps_pkg::SAMPLE_W-1:0]   m_sample_reg, m_sample_next;

    // Memory read data and the sign of the sine quadrant.
    logic [etps_pkg::PCM_DATA_W-1:0] pcm_rd_reg;
    logic [etps_pkg::SINE_MAG_W-1:0] sine_rd_reg;
    logic                            sine_neg_reg;

    // ------------------------------------------------------------------
    // Field unpacking
    // ------------------------------------------------------------------
    logic                              s_fire;
    logic                              s_enable;
    logic [etps_pkg::PCM_ADDR_W-1:0]   s_pcm_addr;
    logic [etps_pkg::PCM_DATA_W-1:0]   s_pcm_data;
    etps_pkg::req_type_t               s_req;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_enable      = s_axis_tdata[0];
    assign s_pcm_addr    = s_axis_tdata[12:1];
    assign s_pcm_data    = s_axis_tdata[28:13];
    assign s_req         = etps_pkg::req_type_t'(s_axis_tuser);

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic               cfg_we;
    etps_pkg::cfg_reg_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = etps_pkg::cfg_reg_t'(paddr[4:2]);

    always_comb begin
        case (cfg_idx)
            etps_pkg::REG_MODE:       prdata = 32'(mode_reg);
            etps_pkg::REG_PHASE_STEP: prdata = phase_step_reg;
            etps_pkg::REG_ENV_COUNT:  prdata = 32'(env_count_reg);
            etps_pkg::REG_PCM_LENGTH: prdata = 32'(pcm_length_reg);
            etps_pkg::REG_PCM_HOLD:   prdata = 32'(pcm_hold_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective settings: zero counts act as one, table length clamped.
    // ------------------------------------------------------------------
    logic [ENV_W-1:0] count_eff;
    logic [ENV_W-1:0] hold_eff;
    logic [LEN_W-1:0] len_raw;
    logic [LEN_W-1:0] len_eff;

    assign count_eff = (env_count_reg == '0) ? ENV_W'(1) : env_count_reg;
    assign hold_eff  = (pcm_hold_reg == '0) ? ENV_W'(1) : pcm_hold_reg;
    assign len_raw   = LEN_W'(pcm_length_reg);

    always_comb begin
        if (len_raw == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_raw > LEN_W'(PCM_DEPTH)) begin
            len_eff = LEN_W'(PCM_DEPTH);
        end else begin
            len_eff = len_raw;
        end
    end

    // ------------------------------------------------------------------
    // Sine quarter-wave ROM, index 0 to QSIZE inclusive.
    // ------------------------------------------------------------------
    logic [etps_pkg::SINE_MAG_W-1:0] sine_rom [QSIZE+1];

    for (genvar g = 0; g <= QSIZE; g++) begin : g_sine_rom
        assign sine_rom[g] = etps_pkg::quarter_sine(g, SINE_ADDR_BITS);
    end

    logic [SINE_ADDR_BITS-1:0]   sine_n;
    logic [1:0]                  sine_quad;
    logic [SINE_ADDR_BITS-3:0]   sine_k;
    logic [SINE_IDX_W-1:0]       sine_idx;

    assign sine_n    = phase_acc_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign sine_quad = sine_n[SINE_ADDR_BITS-1 -: 2];
    assign sine_k    = sine_n[SINE_ADDR_BITS-3:0];
    assign sine_idx  = sine_quad[0] ? (SINE_IDX_W'(QSIZE) - SINE_IDX_W'(sine_k))
                                    : SINE_IDX_W'(sine_k);

    // ------------------------------------------------------------------
    // PCM play position for the current tick.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  pos_ext;
    logic [LEN_W-1:0]  pos_clamped;
    logic [PPOS_W-1:0] pos_eff;
    logic [ENV_W-1:0]  hold_inc;

    assign pos_ext     = LEN_W'(play_pos_reg);
    assign pos_clamped = (pos_ext >= len_eff) ? (len_eff - LEN_W'(1)) : pos_ext;
    assign pos_eff     = PPOS_W'(pos_clamped);
    assign hold_inc    = hold_count_reg + ENV_W'(1);

    // ------------------------------------------------------------------
    // Envelope terms for the current tick.
    // ------------------------------------------------------------------
    logic [ENV_W-1:0] env_num;
    logic [ENV_W:0]   env_pos_inc;
    logic             env_sat;

    always_comb begin
        if (env_phase_reg == ENV_UP) begin
            env_num = env_pos_reg;
        end else if (env_pos_reg >= count_eff) begin
            env_num = '0;
        end else begin
            env_num = count_eff - env_pos_reg;
        end
    end

    assign env_pos_inc = {1'b0, env_pos_reg} + (ENV_W+1)'(1);
    assign env_sat     = (env_num >= count_eff);

    // One restoring division step.
    logic [ENV_W:0] div_shift;
    logic           div_bit;

    assign div_shift = {rem_reg, 1'b0};
    assign div_bit   = (div_shift >= {1'b0, count_eff});

    // Source magnitude and sign for the multiply stage.
    logic [etps_pkg::SAMPLE_W-1:0] pcm_ext;
    logic [etps_pkg::SAMPLE_W-1:0] pcm_x3;
    logic [etps_pkg::SAMPLE_W-1:0] pcm_abs;
    logic [etps_pkg::SRC_MAG_W-1:0] src_mag;
    logic                           src_neg;

    assign pcm_ext = {{(etps_pkg::SAMPLE_W - etps_pkg::PCM_DATA_W){pcm_rd_reg[15]}},
                      pcm_rd_reg};
    assign pcm_x3  = pcm_ext + {pcm_ext[etps_pkg::SAMPLE_W-2:0], 1'b0};
    assign pcm_abs = pcm_x3[etps_pkg::SAMPLE_W-1] ? (~pcm_x3 + 1'b1) : pcm_x3;

    always_comb begin
        if (mode_reg) begin
            src_mag = pcm_abs[etps_pkg::SRC_MAG_W-1:0];
            src_neg = pcm_x3[etps_pkg::SAMPLE_W-1];
        end else begin
            src_mag = etps_pkg::SRC_MAG_W'(sine_rd_reg);
            src_neg = sine_neg_reg;
        end
    end

    // Truncated product back to a signed sample.
    logic [etps_pkg::SAMPLE_W-1:0] res_mag;
    logic [etps_pkg::SAMPLE_W-1:0] res_val;

    assign res_mag = prod_reg[PROD_W-1 -: etps_pkg::SAMPLE_W];
    assign res_val = neg_reg ? (~res_mag + 1'b1) : res_mag;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic              pcm_we;
    logic              pcm_re;
    logic              sine_re;
    logic [PPOS_W-1:0] pcm_waddr;

    assign pcm_waddr = PPOS_W'(s_pcm_addr);
    assign pcm_we    = s_fire && (s_req == etps_pkg::REQ_PCM_WRITE) &&
                       (32'(s_pcm_addr) < 32'(PCM_DEPTH));
    assign pcm_re    = s_fire && (s_req == etps_pkg::REQ_TICK) &&
                       (env_phase_reg != ENV_SILENT) && mode_reg;
    assign sine_re   = s_fire && (s_req == etps_pkg::REQ_TICK) &&
                       (env_phase_reg != ENV_SILENT) && !mode_reg;

    // ------------------------------------------------------------------
    // Sequencer next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        env_phase_next  = env_phase_reg;
        env_pos_next    = env_pos_reg;
        phase_acc_next  = phase_acc_reg;
        play_pos_next   = play_pos_reg;
        hold_count_next = hold_count_reg;
        div_cnt_next    = div_cnt_reg;
        rem_next        = rem_reg;
        scale_next      = scale_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_sample_next   = m_sample_reg;

        if (m_tvalid_reg && m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_req)
                        etps_pkg::REQ_ENABLE: begin
                            if (s_enable) begin
                                if (env_phase_reg == ENV_SILENT ||
                                    env_phase_reg == ENV_DOWN) begin
                                    env_pos_next   = '0;
                                    env_phase_next = ENV_UP;
                                end
                            end else if (env_phase_reg == ENV_UP ||
                                         env_phase_reg == ENV_ACTIVE) begin
                                env_pos_next   = '0;
                                env_phase_next = ENV_DOWN;
                            end
                        end
                        etps_pkg::REQ_PCM_WRITE: begin
                            if (pcm_we) begin
                                play_pos_next   = '0;
                                hold_count_next = '0;
                            end
                        end
                        etps_pkg::REQ_TICK: begin
                            if (env_phase_reg == ENV_SILENT) begin
                                prod_next  = '0;
                                neg_next   = 1'b0;
                                state_next = S_OUT;
                            end else begin
                                // Envelope scale and ramp progress.
                                if (env_phase_reg == ENV_ACTIVE || env_sat) begin
                                    scale_next = etps_pkg::SCALE_ONE;
                                    state_next = S_MUL;
                                end else begin
                                    scale_next   = '0;
                                    rem_next     = env_num;
                                    div_cnt_next = DIV_CNT_W'(etps_pkg::ENV_FRAC_BITS);
                                    state_next   = S_DIV;
                                end
                                if (env_phase_reg != ENV_ACTIVE) begin
                                    if (env_pos_inc >= {1'b0, count_eff}) begin
                                        env_phase_next = (env_phase_reg == ENV_UP) ?
                                                         ENV_ACTIVE : ENV_SILENT;
                                    end
                                    env_pos_next = env_pos_inc[ENV_W-1:0];
                                end
                                // Source position advance.
                                if (mode_reg) begin
                                    if (hold_inc >= hold_eff) begin
                                        hold_count_next = '0;
                                        if ((pos_clamped + LEN_W'(1)) < len_eff) begin
                                            play_pos_next = pos_eff + PPOS_W'(1);
                                        end else begin
                                            play_pos_next = pos_eff;
                                        end
                                    end else begin
                                        hold_count_next = hold_inc;
                                        play_pos_next   = pos_eff;
                                    end
                                end else begin
                                    phase_acc_next = phase_acc_reg +
                                                     PHASE_BITS'(phase_step_reg);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                rem_next     = div_bit ? ENV_W'(div_shift - {1'b0, count_eff})
                                       : div_shift[ENV_W-1:0];
                scale_next   = {scale_reg[ENV_W-2:0], div_bit};
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(src_mag * scale_reg);
                neg_next   = src_neg;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_sample_next = res_val;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            env_phase_reg  <= ENV_SILENT;
            env_pos_reg    <= '0;
            phase_acc_reg  <= '0;
            play_pos_reg   <= '0;
            hold_count_reg <= '0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            mode_reg       <= 1'b0;
            phase_step_reg <= '0;
            env_count_reg  <= etps_pkg::ENV_COUNT_RST;
            pcm_length_reg <= etps_pkg::PCM_LENGTH_RST;
            pcm_hold_reg   <= etps_pkg::PCM_HOLD_RST;
        end else begin
            state_reg      <= state_next;
            env_phase_reg  <= env_phase_next;
            env_pos_reg    <= env_pos_next;
            phase_acc_reg  <= phase_acc_next;
            play_pos_reg   <= play_pos_next;
            hold_count_reg <= hold_count_next;
            div_cnt_reg    <= div_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_idx)
                    etps_pkg::REG_MODE:       mode_reg       <= pwdata[0];
                    etps_pkg::REG_PHASE_STEP: phase_step_reg <= pwdata;
                    etps_pkg::REG_ENV_COUNT:  env_count_reg  <= pwdata[ENV_W-1:0];
                    etps_pkg::REG_PCM_LENGTH: pcm_length_reg <= pwdata[etps_pkg::PCM_LEN_W-1:0];
                    etps_pkg::REG_PCM_HOLD:   pcm_hold_reg   <= pwdata[ENV_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        scale_reg    <= scale_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        m_sample_reg <= m_sample_next;
    end

    // ------------------------------------------------------------------
    // PCM table memory and sine ROM, registered reads.
    // ------------------------------------------------------------------
    logic [etps_pkg::PCM_DATA_W-1:0] pcm_mem [PCM_DEPTH];

    always_ff @(posedge aclk) begin
        if (pcm_we) begin
            pcm_mem[pcm_waddr] <= s_pcm_data;
        end
        if (pcm_re) begin
            pcm_rd_reg <= pcm_mem[pos_eff];
        end
    end

    always_ff @(posedge aclk) begin
        if (sine_re) begin
            sine_rd_reg  <= sine_rom[sine_idx];
            sine_neg_reg <= sine_quad[1];
        end
    end

    // Output ports.
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {(24 - etps_pkg::SAMPLE_W)'(0), m_sample_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (scale_reg <= etps_pkg::SCALE_ONE))
        else $error("envelope scale above one");

    a_play_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(play_pos_reg) < 32'(PCM_DEPTH))
        else $error("play position beyond table");

    a_non_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_req != etps_pkg::REQ_TICK) |=> (state_reg == S_IDLE))
        else $error("non-tick beat left the idle state");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("sample presented outside the output step");

    a_div_only_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_cnt_reg != '0))
        else $error("divider running with no steps left");

endmodule

@@ verif/synth_sample_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synth_sample_checker
// Watches the configuration port and both streams of the enveloped tone / PCM
// source, predicts every sample and compares it with the sample beat seen.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the registers, the envelope, the phase
// accumulator, the play position and the PCM table. Each accepted request
// beat is applied to that copy. A tick pushes the predicted sample into a
// queue, and each accepted sample beat is compared with the oldest entry.
module synth_sample_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // tdata: enable [0], pcm_addr [12:1], pcm_data [28:13], zero [31:29]
    input  logic [31:0] s_axis_tdata,
    // tuser: req_type [1:0]
    input  logic [1:0]  s_axis_tuser,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: sample [17:0], zero [23:18]
    input  logic [23:0] m_axis_tdata,

    output int          results_due,
    output int          mismatches
);

    localparam int SINE_BITS     = etps_pkg::SINE_ADDR_BITS_DEF;
    localparam int QUARTER_STEPS = 1 << (SINE_BITS - 2);
    localparam int SCALE_FULL    = 1 << etps_pkg::ENV_FRAC_BITS;
    localparam int SAMPLE_W      = etps_pkg::SAMPLE_W;
    localparam int STEP_W        = etps_pkg::STEP_W;
    localparam int ENV_W         = etps_pkg::ENV_W;
    localparam int PCM_LEN_W     = etps_pkg::PCM_LEN_W;
    localparam int PCM_DATA_W    = etps_pkg::PCM_DATA_W;
    localparam int PCM_ADDR_W    = etps_pkg::PCM_ADDR_W;
    localparam int PCM_DEPTH     = etps_pkg::PCM_DEPTH_DEF;

    typedef enum logic [1:0] {
        ENV_QUIET,
        ENV_RISING,
        ENV_FULL,
        ENV_FALLING
    } env_state_t;

    // Predicted samples, oldest first.
    logic [SAMPLE_W-1:0]   samples_due [$];
    int                    mismatch_count;

    // First-quadrant sine magnitudes, Q15, one more point than a quarter.
    int unsigned           quarter_mag [0:QUARTER_STEPS];

    // Register copies.
    logic                  cfg_mode;
    logic [STEP_W-1:0]     cfg_step;
    logic [ENV_W-1:0]      cfg_ramp;
    logic [PCM_LEN_W-1:0]  cfg_len;
    logic [ENV_W-1:0]      cfg_hold;

    // Source and envelope state.
    env_state_t            env_state;
    logic [ENV_W-1:0]      env_ticks;
    logic [STEP_W-1:0]     phase;
    int unsigned           play_idx;
    logic [ENV_W-1:0]      hold_ticks;
    logic [PCM_DATA_W-1:0] pcm_words [PCM_DEPTH];

    // Sine magnitude at quarter-wave index idx: odd Taylor polynomial to
    // degree 11, evaluated in unsigned Q30 with truncated products.
    function automatic int unsigned sine_mag_q15(input int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned poly;
        longint unsigned mag;
        x    = 64'(idx) << (30 - (SINE_BITS - 2));
        x2   = (x * x) >> 30;
        poly = 64'd3864;
        poly = 64'd172272 - ((x2 * poly) >> 30);
        poly = 64'd5026995 - ((x2 * poly) >> 30);
        poly = 64'd85569304 - ((x2 * poly) >> 30);
        poly = 64'd693598669 - ((x2 * poly) >> 30);
        poly = 64'd1686629713 - ((x2 * poly) >> 30);
        mag  = (((x * poly) >> 30) + 64'd16384) >> 15;
        return (mag > 64'd32767) ? 32'd32767 : 32'(mag);
    endfunction

    // Signed sine value for the top bits of the phase, by quadrant symmetry.
    function automatic int sine_q15(input logic [STEP_W-1:0] ph);
        logic [SINE_BITS-1:0] n;
        int unsigned          k;
        int unsigned          idx;
        int                   m;
        n   = ph[STEP_W-1 -: SINE_BITS];
        k   = 32'(n[SINE_BITS-3:0]);
        idx = n[SINE_BITS-2] ? QUARTER_STEPS - k : k;
        m   = int'(quarter_mag[idx]);
        return n[SINE_BITS-1] ? -m : m;
    endfunction

    initial begin
        for (int i = 0; i <= QUARTER_STEPS; i++) begin
            quarter_mag[i] = sine_mag_q15(i);
        end
    end

    // Work out the sample of one tick and advance envelope and source.
    task automatic step_tick(output logic [SAMPLE_W-1:0] smp);
        int unsigned           ramp;
        int unsigned           scale;
        int unsigned           num;
        int unsigned           len;
        int unsigned           hold;
        longint                src;
        longint                mag;
        logic [PCM_DATA_W-1:0] w;
        if (env_state == ENV_QUIET) begin
            smp = '0;
            return;
        end
        ramp  = (cfg_ramp == 0) ? 1 : 32'(cfg_ramp);
        scale = SCALE_FULL;

        // Ramp scale; a ramp shortened under way ends at once, rising at full scale and falling at zero.
        if (env_state == ENV_RISING || env_state == ENV_FALLING) begin
            if (env_state == ENV_RISING) begin
                num = 32'(env_ticks);
            end else begin
                num = (env_ticks >= ramp) ? 0 : ramp - env_ticks;
            end
            scale = (num << etps_pkg::ENV_FRAC_BITS) / ramp;
            if (scale > SCALE_FULL) begin
                scale = SCALE_FULL;
            end
            if (env_ticks + 1 >= ramp) begin
                env_state = (env_state == ENV_RISING) ? ENV_FULL : ENV_QUIET;
            end
            env_ticks = env_ticks + 1'b1;
        end

        // Source word: sine at the current phase or the current table entry.
        if (!cfg_mode) begin
            src   = longint'(sine_q15(phase));
            phase = phase + cfg_step;
        end else begin
            len  = (cfg_len == 0) ? 1 : 32'(cfg_len);
            if (len > PCM_DEPTH) begin
                len = PCM_DEPTH;
            end
            hold = (cfg_hold == 0) ? 1 : 32'(cfg_hold);
            if (play_idx >= len) begin
                play_idx = len - 1;
            end
            w          = pcm_words[play_idx];
            src        = 3 * longint'($signed(w));
            hold_ticks = hold_ticks + 1'b1;
            if (hold_ticks >= hold) begin
                hold_ticks = '0;
                if (play_idx + 1 < len) begin
                    play_idx++;
                end
            end
        end

        // Scale the magnitude and truncate toward zero.
        mag = (src < 0) ? -src : src;
        mag = (mag * longint'(scale)) >> etps_pkg::ENV_FRAC_BITS;
        mag = (src < 0) ? -mag : mag;
        smp = mag[SAMPLE_W-1:0];
    endtask

    // Apply one accepted request beat.
    task automatic apply_request(input logic [1:0] kind, input logic [31:0] data);
        logic [SAMPLE_W-1:0] smp;
        case (kind)
            etps_pkg::REQ_TICK: begin
                step_tick(smp);
                samples_due.push_back(smp);
            end
            etps_pkg::REQ_ENABLE: begin
                if (data[0]) begin
                    if (env_state == ENV_QUIET || env_state == ENV_FALLING) begin
                        env_ticks = '0;
                        env_state = ENV_RISING;
                    end
                end else if (env_state == ENV_RISING || env_state == ENV_FULL) begin
                    env_ticks = '0;
                    env_state = ENV_FALLING;
                end
            end
            etps_pkg::REQ_PCM_WRITE: begin
                pcm_words[data[PCM_ADDR_W:1]] = data[PCM_ADDR_W+PCM_DATA_W:PCM_ADDR_W+1];
                play_idx   = 0;
                hold_ticks = '0;
            end
            default: begin
                // Unknown requests change nothing.
            end
        endcase
    endtask

    // Sample beats are compared before request beats of the same edge are
    // applied, since a beat leaving now always belongs to an older tick.
    always @(posedge aclk) begin : watch_beats
        logic [SAMPLE_W-1:0] want;
        logic [SAMPLE_W-1:0] got;
        if (!aresetn) begin
            samples_due.delete();
            mismatch_count = 0;
            cfg_mode       = 1'b0;
            cfg_step       = '0;
            cfg_ramp       = etps_pkg::ENV_COUNT_RST;
            cfg_len        = etps_pkg::PCM_LENGTH_RST;
            cfg_hold       = etps_pkg::PCM_HOLD_RST;
            env_state      = ENV_QUIET;
            env_ticks      = '0;
            phase          = '0;
            play_idx       = 0;
            hold_ticks     = '0;
        end else begin
            // Register writes.
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    etps_pkg::REG_MODE:       cfg_mode = pwdata[0];
                    etps_pkg::REG_PHASE_STEP: cfg_step = pwdata[STEP_W-1:0];
                    etps_pkg::REG_ENV_COUNT:  cfg_ramp = pwdata[ENV_W-1:0];
                    etps_pkg::REG_PCM_LENGTH: cfg_len  = pwdata[PCM_LEN_W-1:0];
                    etps_pkg::REG_PCM_HOLD:   cfg_hold = pwdata[ENV_W-1:0];
                    default: ;
                endcase
            end

            // Sample beats against the oldest prediction.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[SAMPLE_W-1:0];
                if (samples_due.size() == 0) begin
                    $display("%0t: sample beat with nothing expected, actual %0d",
                             $time, $signed(got));
                    mismatch_count++;
                end else begin
                    want = samples_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: sample mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), $signed(got));
                        mismatch_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(s_axis_tuser, s_axis_tdata);
            end
        end
        results_due <= samples_due.size();
        mismatches  <= mismatch_count;
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the enveloped tone / PCM audio source.
// ----------------------------------------------------------------------------
// A short directed part covers silent ticks, ignored requests, the ramp of
// zero length, the sine peaks, the PCM extremes, table length and hold values
// out of range, playback stopping at the last entry and ramps shortened while
// under way. The first table entries are loaded once, and every random phase
// starts with a table write that rewinds playback, so that a phase has fewer
// ticks than loaded entries and no unwritten entry is ever played. Random
// phases then change all registers while the block is idle and send mostly
// ticks with some enable events, table writes and unknown requests. Both
// streams idle in random bursts except at the end.
module testbench;

    localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
    localparam int         RANDOM_PHASES = 12;
    localparam int         PHASE_BEATS   = 145;
    localparam int         LOADED_WORDS  = 256;
    localparam int         SETTLE_LIMIT  = 20000;
    localparam int         ADDR_W        = etps_pkg::PCM_ADDR_W;
    localparam int         DATA_W        = etps_pkg::PCM_DATA_W;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;

    int          results_due;
    int          mismatches;
    // Set for the last part of the run: no idling on either side.
    bit          calm          = 1'b0;

    enveloped_tone_pcm_synth dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    synth_sample_checker sample_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .results_due   (results_due),
        .mismatches    (mismatches)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard limit on the run.
    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    // The sample side stalls in random bursts.
    initial begin : sample_stalls
        forever begin
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // One request beat, sometimes after a burst of idle cycles.
    task automatic send_beat(input logic [1:0] kind, input logic en,
                             input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] word);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, word, addr, en};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Fields that a beat does not use carry random values.
    task automatic tick();
        send_beat(etps_pkg::REQ_TICK, 1'($urandom), 12'($urandom), 16'($urandom));
    endtask

    task automatic set_enable(input logic en);
        send_beat(etps_pkg::REQ_ENABLE, en, 12'($urandom), 16'($urandom));
    endtask

    task automatic store_word(input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] word);
        send_beat(etps_pkg::REQ_PCM_WRITE, 1'($urandom), addr, word);
    endtask

    // Stop sending, wait for every sample still due, then let the block
    // finish any request that gives no sample.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        for (int w = 0; w < SETTLE_LIMIT && results_due != 0; w++) begin
            @(posedge aclk);
        end
        repeat (30) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic cfg_write(input etps_pkg::cfg_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int          r;
        logic [31:0] step_v;
        logic [31:0] ramp_v;
        logic [31:0] len_v;
        logic [31:0] hold_v;
        logic        mode_v;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Silent envelope: zero sample; unknown request and a stop are ignored.
        tick();
        send_beat(REQ_UNKNOWN, 1'b1, 12'hFFF, 16'hFFFF);
        set_enable(1'b0);
        settle();

        // Ramp of zero length acts as one tick; quarter-turn steps reach
        // both sine peaks and the zero crossings.
        cfg_write(etps_pkg::REG_ENV_COUNT, 32'd0);
        cfg_write(etps_pkg::REG_PHASE_STEP, 32'h4000_0000);
        set_enable(1'b1);
        repeat (4) tick();
        set_enable(1'b1);
        set_enable(1'b0);
        tick();
        tick();
        settle();

        // Load the first table entries; the first ones hold the word extremes.
        for (int a = 0; a < LOADED_WORDS; a++) begin
            case (a)
                0:       store_word(12'(a), 16'h0000);
                1:       store_word(12'(a), 16'h8000);
                2:       store_word(12'(a), 16'h7FFF);
                3:       store_word(12'(a), 16'hFFFF);
                default: store_word(12'(a), 16'($urandom));
            endcase
        end
        settle();

        // PCM playback with table length above the depth and zero hold.
        cfg_write(etps_pkg::REG_MODE, 32'd1);
        cfg_write(etps_pkg::REG_PCM_LENGTH, 32'd8191);
        cfg_write(etps_pkg::REG_PCM_HOLD, 32'd0);
        set_enable(1'b1);
        repeat (4) tick();
        settle();

        // Short table: playback clamps to and stays on the last entry.
        cfg_write(etps_pkg::REG_PCM_LENGTH, 32'd2);
        cfg_write(etps_pkg::REG_PCM_HOLD, 32'd1);
        tick();
        tick();
        settle();

        // Falling ramp cut short by a lower ramp length.
        cfg_write(etps_pkg::REG_ENV_COUNT, 32'd100);
        set_enable(1'b0);
        tick();
        tick();
        settle();
        cfg_write(etps_pkg::REG_ENV_COUNT, 32'd2);
        tick();
        settle();

        // Rising ramp cut short: the scale saturates at one.
        cfg_write(etps_pkg::REG_ENV_COUNT, 32'd100);
        set_enable(1'b1);
        repeat (3) tick();
        settle();
        cfg_write(etps_pkg::REG_ENV_COUNT, 32'd2);
        tick();
        settle();

        // Random phases, each with new register values.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p >= RANDOM_PHASES - 2);
            mode_v = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0:       step_v = 32'd0;
                1:       step_v = 32'hFFFF_FFFF;
                2:       step_v = $urandom_range(1, 32'h0100_0000);
                default: step_v = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       ramp_v = 32'd0;
                1:       ramp_v = 32'd1;
                2:       ramp_v = $urandom_range(2, 8);
                3:       ramp_v = $urandom_range(9, 60);
                4:       ramp_v = $urandom_range(61, 400);
                default: ramp_v = 32'd65535;
            endcase
            case ($urandom_range(0, 5))
                0:       len_v = 32'd0;
                1:       len_v = 32'd1;
                2:       len_v = $urandom_range(2, 16);
                3:       len_v = $urandom_range(17, 4096);
                4:       len_v = 32'd4096;
                default: len_v = $urandom_range(4097, 8191);
            endcase
            case ($urandom_range(0, 4))
                0:       hold_v = 32'd0;
                1:       hold_v = 32'd1;
                2:       hold_v = $urandom_range(2, 4);
                3:       hold_v = $urandom_range(5, 300);
                default: hold_v = 32'd65535;
            endcase
            // Fixed corners: both modes early, and the largest step,
            // ramp and hold together in one tone phase.
            if (p < 2) begin
                mode_v = p[0];
            end
            if (p == 2) begin
                mode_v = 1'b0;
                step_v = 32'hFFFF_FFFF;
                ramp_v = 32'd65535;
                hold_v = 32'd65535;
            end
            cfg_write(etps_pkg::REG_MODE, {31'd0, mode_v});
            cfg_write(etps_pkg::REG_PHASE_STEP, step_v);
            cfg_write(etps_pkg::REG_ENV_COUNT, ramp_v);
            cfg_write(etps_pkg::REG_PCM_LENGTH, len_v);
            cfg_write(etps_pkg::REG_PCM_HOLD, hold_v);

            // Rewind playback so that it stays inside the loaded entries.
            store_word(12'($urandom_range(0, LOADED_WORDS - 1)), 16'($urandom));

            // Mostly ticks; enables lean toward switching the sound on.
            set_enable(1'b1);
            for (int b = 0; b < PHASE_BEATS; b++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    set_enable($urandom_range(0, 9) < 7);
                end else if (r < 7) begin
                    store_word(12'($urandom), 16'($urandom));
                end else if (r < 9) begin
                    send_beat(REQ_UNKNOWN, 1'($urandom), 12'($urandom), 16'($urandom));
                end else begin
                    tick();
                end
            end
            settle();
        end

        if (mismatches == 0 && results_due == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/etps_pkg.sv
hw/rtl/enveloped_tone_pcm_synth.sv
verif/synth_sample_checker.sv
verif/testbench.sv
